>>> src/fpe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpe_pkg
// Shared types, constants and helpers of the framebuffer pixel engine.
// ----------------------------------------------------------------------------
package fpe_pkg;

	localparam int STORE_BYTES = 65536;
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	localparam int ROW_W       = ADDR_W - 1;
	localparam int BANK_ROWS   = STORE_BYTES / 2;

	localparam int IN_DATA_W   = 128;
	localparam int IN_USER_W   = 3;
	localparam int OUT_DATA_W  = 24;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [1:0] FUNC_GET  = 2'd0;
	localparam logic [1:0] FUNC_FILL = 2'd1;
	localparam logic [1:0] FUNC_DRAW = 2'd2;

	localparam logic [1:0] STAT_OK          = 2'd0;
	localparam logic [1:0] STAT_BAD_PARAM   = 2'd1;
	localparam logic [1:0] STAT_UNSUPPORTED = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_BITMAP_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BITMAP_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BPP           = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE    = 3'd4;

	localparam logic [31:0] COLOUR_NONE = 32'hffff_ffff;
	localparam logic [31:0] ROP_XOR     = 32'd1;

	localparam logic [7:0] BPP_NATIVE = 8'd16;
	localparam logic [2:0] LG_BYTE    = 3'd3;
	localparam logic [2:0] LG_NATIVE  = 3'd4;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_MUL,
		ST_BASE,
		ST_GREAD,
		ST_GWAIT,
		ST_FILL,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [15:0]       wr_data;
		logic [ADDR_W-1:0] rd_addr;
	} mem_req_t;

	typedef struct packed {
		logic       ok;
		logic [2:0] lg;
	} depth_t;

	function automatic depth_t depth_decode(input logic [7:0] bpp);
		depth_t d;
		d.ok = 1'b1;
		d.lg = 3'd0;
		unique case (bpp)
			8'd1:  d.lg = 3'd0;
			8'd2:  d.lg = 3'd1;
			8'd4:  d.lg = 3'd2;
			8'd8:  d.lg = LG_BYTE;
			8'd16: d.lg = LG_NATIVE;
			default: d.ok = 1'b0;
		endcase
		return d;
	endfunction

endpackage
`default_nettype wire

>>> src/fpe_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpe_store
// Byte-addressed frame store split into an even and an odd byte bank, so that
// a halfword at any address, wrapping at the end, is one access to each bank.
// Read data is registered; a write in the cycle of a read to the same
// row is forwarded. After reset every row is cleared, one row per cycle.
// ----------------------------------------------------------------------------
module fpe_store (
	input  wire                   clk,
	input  wire                   arst_n,
	input  fpe_pkg::mem_req_t     req,
	output logic [15:0]           rd_data,
	output logic                  ready
);
	import fpe_pkg::*;

	logic [7:0] bank_even [BANK_ROWS];
	logic [7:0] bank_odd  [BANK_ROWS];

	logic             clr_busy_q;
	logic [ROW_W-1:0] clr_row_q;

	logic [ROW_W-1:0] wr_row, rd_row;
	logic             even_we, odd_we;
	logic [ROW_W-1:0] even_wrow, odd_wrow, even_rrow, odd_rrow;
	logic [7:0]       even_wd, odd_wd;

	logic [7:0]       even_q, odd_q;
	logic             fw_even_s1, fw_odd_s1, rd_lsb_s1;
	logic [7:0]       fw_even_data_s1, fw_odd_data_s1;
	logic [7:0]       even_val, odd_val;

	assign wr_row    = req.wr_addr[ADDR_W-1:1];
	assign rd_row    = req.rd_addr[ADDR_W-1:1];
	assign even_rrow = req.rd_addr[0] ? rd_row + ROW_W'(1) : rd_row;
	assign odd_rrow  = rd_row;

	always_comb begin
		if (clr_busy_q) begin
			even_we   = 1'b1;
			odd_we    = 1'b1;
			even_wrow = clr_row_q;
			odd_wrow  = clr_row_q;
			even_wd   = 8'd0;
			odd_wd    = 8'd0;
		end else begin
			even_we   = req.wr_en;
			odd_we    = req.wr_en;
			even_wrow = req.wr_addr[0] ? wr_row + ROW_W'(1) : wr_row;
			odd_wrow  = wr_row;
			even_wd   = req.wr_addr[0] ? req.wr_data[15:8] : req.wr_data[7:0];
			odd_wd    = req.wr_addr[0] ? req.wr_data[7:0] : req.wr_data[15:8];
		end
	end

	always_ff @(posedge clk) begin
		even_q <= bank_even[even_rrow];
		odd_q  <= bank_odd[odd_rrow];
		if (even_we) begin
			bank_even[even_wrow] <= even_wd;
		end
		if (odd_we) begin
			bank_odd[odd_wrow] <= odd_wd;
		end
		fw_even_data_s1 <= even_wd;
		fw_odd_data_s1  <= odd_wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_row_q  <= '0;
			fw_even_s1 <= 1'b0;
			fw_odd_s1  <= 1'b0;
			rd_lsb_s1  <= 1'b0;
		end else begin
			fw_even_s1 <= even_we && (even_wrow == even_rrow);
			fw_odd_s1  <= odd_we && (odd_wrow == odd_rrow);
			rd_lsb_s1  <= req.rd_addr[0];
			if (clr_busy_q) begin
				clr_row_q <= clr_row_q + ROW_W'(1);
				if (clr_row_q == ROW_W'(BANK_ROWS - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
		end
	end

	assign even_val = fw_even_s1 ? fw_even_data_s1 : even_q;
	assign odd_val  = fw_odd_s1 ? fw_odd_data_s1 : odd_q;
	assign rd_data  = rd_lsb_s1 ? {even_val, odd_val} : {odd_val, even_val};
	assign ready    = !clr_busy_q;

endmodule
`default_nettype wire

>>> src/framebuffer_pixel_engine_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// framebuffer_pixel_engine_core
// Pixel engine on a byte-addressed frame store: get pixel, fill rectangle
// and draw pixel, with clipping and XOR; packed pixel depths are for get only.
// ----------------------------------------------------------------------------
//  port group   role    word contents
//  s_axis_*     in      one operation (tdata: positions, sizes, colour, rop)
//  m_axis_*     out     one result (tdata: status, pixel value)
//  cfg_*        in      one register write (index, data)
//
//  A get passes the check, multiply, base, read and wait states. A fill or
//  draw sets up in the check, multiply and base states, then does one
//  clipped pixel per cycle in the fill state as a read-modify-write of the
//  store, and drains. A word that is rejected or paints nothing goes from
//  the check state to the done state. The next word can be taken in the
//  cycle after a result enters the output register. After reset all 32768
//  rows are cleared, and s_axis_tready rises in the cycle after that.
//  One finished result waits in the output register while the next word is
//  taken; a later result waits until that register is free.
// ----------------------------------------------------------------------------
module framebuffer_pixel_engine_core (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             s_axis_tvalid,
	output logic                            s_axis_tready,
	// pos_x[15:0] pos_y[31:16] rect_width[47:32] rect_height[63:48]
	// colour[95:64] raster_op[127:96]
	input  wire [fpe_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// func[1:0] whole_bitmap[2]
	input  wire [fpe_pkg::IN_USER_W-1:0]    s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  wire                             m_axis_tready,
	// status[1:0] pixel_value[17:2] zeros[23:18]
	output logic [fpe_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire [fpe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [fpe_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import fpe_pkg::*;

	state_t state_q, state_d;

	logic [14:0] width_q, height_q;
	logic [15:0] pitch_q, base_q;
	logic [7:0]  bpp_q;

	logic [1:0]         func_q;
	logic signed [15:0] pos_x_q, pos_y_q, rect_w_q, rect_h_q;
	logic               whole_q, colour_none_q, xor_q;
	logic [15:0]        colour_q;

	logic [14:0]       x0_q, x1_q, y1_q, x_q, y_q;
	logic [2:0]        lg_q, bitsel_q;
	logic [ADDR_W-1:0] prod_q, xoff_q, row_q, pix_addr_q, addr_s1;
	logic              valid_s1;
	logic [1:0]        res_status_q;
	logic [15:0]       res_pixel_q;
	logic              m_valid_q;
	logic [1:0]        m_status_q;
	logic [15:0]       m_pixel_q;

	mem_req_t    mem_req;
	logic [15:0] rd_data;
	logic        store_ready;

	logic              in_take, out_load;
	logic signed [17:0] pxe, pye, wext, hext, rx, ry, rdx, rdy, x0, y0, x1, y1;
	logic              get_oob, paint, x_last, y_last;
	depth_t            dep;
	logic [1:0]        check_status;
	logic [18:0]       xbits;
	logic [ADDR_W-1:0] base_ext, pitch_ext;
	logic [4:0]        dbits;
	logic [3:0]        shamt;
	logic [8:0]        pmask;
	logic [15:0]       pix_val;

	fpe_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (rd_data),
		.ready   (store_ready)
	);

	assign base_ext  = ADDR_W'(base_q);
	assign pitch_ext = ADDR_W'(pitch_q);

	always_comb begin
		pxe  = {{2{pos_x_q[15]}}, pos_x_q};
		pye  = {{2{pos_y_q[15]}}, pos_y_q};
		wext = {3'b000, width_q};
		hext = {3'b000, height_q};
		rx   = pxe;
		ry   = pye;
		rdx  = 18'sd1;
		rdy  = 18'sd1;
		if (func_q == FUNC_FILL) begin
			if (whole_q) begin
				rx  = 18'sd0;
				ry  = 18'sd0;
				rdx = wext;
				rdy = hext;
			end else begin
				rdx = {{2{rect_w_q[15]}}, rect_w_q};
				rdy = {{2{rect_h_q[15]}}, rect_h_q};
			end
		end
		x0 = (rx > 18'sd0) ? rx : 18'sd0;
		y0 = (ry > 18'sd0) ? ry : 18'sd0;
		x1 = rx + rdx;
		y1 = ry + rdy;
		if (x1 > wext) begin
			x1 = wext;
		end
		if (y1 > hext) begin
			y1 = hext;
		end
		get_oob = (pxe < 18'sd0) || (pye < 18'sd0) || (pxe >= wext) || (pye >= hext);
		paint   = !colour_none_q && (bpp_q == BPP_NATIVE) && (x1 > x0) && (y1 > y0);
		dep     = depth_decode(bpp_q);
		unique case (func_q)
			FUNC_GET:  check_status = get_oob ? STAT_BAD_PARAM :
				(dep.ok ? STAT_OK : STAT_UNSUPPORTED);
			FUNC_FILL: check_status = STAT_OK;
			FUNC_DRAW: check_status = STAT_OK;
			default:   check_status = STAT_BAD_PARAM;
		endcase
	end

	assign xbits  = {4'b0000, x0_q} << lg_q;
	assign x_last = ({1'b0, x_q} + 16'd1) == {1'b0, x1_q};
	assign y_last = ({1'b0, y_q} + 16'd1) == {1'b0, y1_q};

	always_comb begin
		dbits   = 5'd1 << lg_q;
		shamt   = 4'd8 - dbits[3:0] - {1'b0, bitsel_q};
		pmask   = (9'd1 << dbits) - 9'd1;
		case (lg_q)
			LG_NATIVE: pix_val = rd_data;
			LG_BYTE:   pix_val = {8'h00, rd_data[7:0]};
			default:   pix_val = {8'h00, (rd_data[7:0] >> shamt[2:0]) & pmask[7:0]};
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (store_ready) state_d = ST_IDLE;
			ST_IDLE:  if (s_axis_tvalid) state_d = ST_CHECK;
			ST_CHECK: begin
				if (func_q == FUNC_GET) begin
					state_d = (get_oob || !dep.ok) ? ST_DONE : ST_MUL;
				end else if (func_q == FUNC_FILL || func_q == FUNC_DRAW) begin
					state_d = paint ? ST_MUL : ST_DONE;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_MUL:   state_d = ST_BASE;
			ST_BASE:  state_d = (func_q == FUNC_GET) ? ST_GREAD : ST_FILL;
			ST_GREAD: state_d = ST_GWAIT;
			ST_GWAIT: state_d = ST_DONE;
			ST_FILL:  if (x_last && y_last) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_DONE;
			ST_DONE:  if (!m_valid_q || m_axis_tready) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		s_axis_tready    = (state_q == ST_IDLE);
		in_take          = s_axis_tvalid && s_axis_tready;
		out_load         = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);
		cfg_ready        = 1'b1;
		mem_req.rd_addr  = pix_addr_q;
		mem_req.wr_en    = valid_s1;
		mem_req.wr_addr  = addr_s1;
		mem_req.wr_data  = colour_q ^ (xor_q ? rd_data : 16'h0000);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			width_q   <= '0;
			height_q  <= '0;
			pitch_q   <= '0;
			bpp_q     <= BPP_NATIVE;
			base_q    <= '0;
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= (state_q == ST_FILL);
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_BITMAP_WIDTH:  width_q  <= cfg_data[14:0];
					CFG_BITMAP_HEIGHT: height_q <= cfg_data[14:0];
					CFG_ROW_PITCH:     pitch_q  <= cfg_data;
					CFG_BPP:           bpp_q    <= cfg_data[7:0];
					CFG_FRAME_BASE:    base_q   <= cfg_data;
					default: ;
				endcase
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= pix_addr_q;
		if (in_take) begin
			func_q        <= s_axis_tuser[1:0];
			whole_q       <= s_axis_tuser[2];
			pos_x_q       <= s_axis_tdata[15:0];
			pos_y_q       <= s_axis_tdata[31:16];
			rect_w_q      <= s_axis_tdata[47:32];
			rect_h_q      <= s_axis_tdata[63:48];
			colour_q      <= s_axis_tdata[79:64];
			colour_none_q <= (s_axis_tdata[95:64] == COLOUR_NONE);
			xor_q         <= (s_axis_tdata[127:96] == ROP_XOR);
		end
		unique case (state_q)
			ST_CHECK: begin
				x0_q         <= x0[14:0];
				x1_q         <= x1[14:0];
				y_q          <= y0[14:0];
				y1_q         <= y1[14:0];
				lg_q         <= (func_q == FUNC_GET) ? dep.lg : LG_NATIVE;
				res_status_q <= check_status;
				res_pixel_q  <= 16'h0000;
			end
			ST_MUL: begin
				prod_q   <= ADDR_W'(ADDR_W'(y_q) * pitch_ext);
				xoff_q   <= ADDR_W'(xbits[18:3]);
				bitsel_q <= xbits[2:0];
				x_q      <= x0_q;
			end
			ST_BASE: begin
				row_q      <= base_ext + prod_q;
				pix_addr_q <= base_ext + prod_q + xoff_q;
			end
			ST_GWAIT: res_pixel_q <= pix_val;
			ST_FILL: begin
				if (!x_last) begin
					x_q        <= x_q + 15'd1;
					pix_addr_q <= pix_addr_q + ADDR_W'(2);
				end else begin
					x_q        <= x0_q;
					y_q        <= y_q + 15'd1;
					row_q      <= row_q + pitch_ext;
					pix_addr_q <= row_q + pitch_ext + xoff_q;
				end
			end
			default: ;
		endcase
		if (out_load) begin
			m_status_q <= res_status_q;
			m_pixel_q  <= res_pixel_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {6'b000000, m_pixel_q, m_status_q};

	a_write_only_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en |-> (state_q == ST_FILL || state_q == ST_DRAIN))
		else $error("store write outside a fill");

	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> store_ready)
		else $error("word accepted before the store was cleared");

	a_read_before_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GWAIT) |-> ($past(state_q) == ST_GREAD))
		else $error("pixel taken without a read in the cycle before");

	a_write_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ($past(state_q) == ST_FILL))
		else $error("write without a matching read");

endmodule
`default_nettype wire
